@@ rtl/core/nct_pkg.sv @@
// Package for the neighbour cache table: operation and status codes, NUD scoring.
// Used by nct_cell, neighbor_cache_table and nct_checker.
package nct_pkg;

  localparam logic [2:0] OP_LOOKUP    = 3'd0;
  localparam logic [2:0] OP_ROUTER    = 3'd1;
  localparam logic [2:0] OP_INSERT    = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_CLR_IFC   = 3'd4;
  localparam logic [2:0] OP_CLR_GRP   = 3'd5;
  localparam logic [2:0] OP_CLR_ALL   = 3'd6;
  localparam logic [2:0] OP_CLR_EXP   = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [7:0] NS_INCOMPLETE = 8'h01;
  localparam logic [7:0] NS_REACHABLE  = 8'h02;
  localparam logic [7:0] NS_STALE      = 8'h04;
  localparam logic [7:0] NS_DELAY      = 8'h08;
  localparam logic [7:0] NS_PROBE      = 8'h10;
  localparam logic [7:0] NS_FAILED     = 8'h20;

  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

  typedef struct packed {
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [3:0]  group_id;
    logic [3:0]  interface_id;
    logic [47:0] link_addr;
    logic        router_flag;
    logic [7:0]  nud_code;
    logic [31:0] expiry;
  } entry_t;

  // Score 0..5; bit 3 marks an unknown code
  function automatic logic [3:0] state_rank(input logic [7:0] code);
    logic [3:0] s;
    begin
      case (code)
        NS_REACHABLE:  s = 4'd5;
        NS_PROBE:      s = 4'd4;
        NS_DELAY:      s = 4'd3;
        NS_STALE:      s = 4'd2;
        NS_INCOMPLETE: s = 4'd1;
        NS_FAILED:     s = 4'd0;
        default:       s = 4'd8;
      endcase
      return s;
    end
  endfunction

endpackage

@@ rtl/core/nct_cell.sv @@
// One slot of the neighbour table, sitting in a circular shift ring.
// Depends on nct_pkg.
module nct_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            clr_all,
  input  logic            load,
  input  nct_pkg::entry_t load_entry,
  input  logic            prev_valid,
  input  nct_pkg::entry_t prev_entry,
  output logic            valid,
  output nct_pkg::entry_t entry
);

  // Advance the ring on shift; a load overwrites the cell after a full turn; reset or clr_all clears valid
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_entry;
    end else if (shift) begin
      entry <= prev_entry;
    end
  end

endmodule

@@ rtl/core/neighbor_cache_table.sv @@
// Top level of the neighbour cache table: handshake, sequencer and cell ring.
// Depends on nct_pkg and nct_cell.
//
//  channel  direction  handshake          payload
//  cfg      in         cfg_we             cfg_wdata (expiry_timeout)
//  request  in         in_valid/in_stall  operation .. now
//  result   out        out_valid/out_stall status .. out_expiry
//
// Every transaction rotates the ring once, each slot passing cell 0 at the
// head, then a commit state writes an insert and loads the output register.
// With no stall the next request is taken after the result leaves: the
// sequencer sees the register empty in S_DONE and returns to idle. A result
// waits in the output register under stall and the next request is taken once
// it leaves. Reset empties the table.
module neighbor_cache_table #(
  parameter int ENTRY_COUNT   = 64,
  parameter int INTERFACE_IDS = 16,
  parameter int GROUP_IDS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [63:0] ip_high,
  input  logic [63:0] ip_low,
  input  logic [3:0]  group_id,
  input  logic [3:0]  interface_id,
  input  logic [47:0] link_addr,
  input  logic        link_addr_valid,
  input  logic        router_flag,
  input  logic [7:0]  nud_code,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        found,
  output logic [63:0] out_ip_high,
  output logic [63:0] out_ip_low,
  output logic [47:0] out_link_addr,
  output logic [3:0]  out_interface_id,
  output logic        out_router_flag,
  output logic [7:0]  out_nud_code,
  output logic [31:0] out_expiry
);

  localparam int CW = $clog2(ENTRY_COUNT);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [31:0] expiry_timeout;
  logic [CW-1:0] cnt;

  // Latched request
  logic [2:0]  op;
  nct_pkg::entry_t req;

  // Walk results
  logic          hit;
  logic [CW-1:0] hit_pos;
  logic          has_free;
  logic [CW-1:0] free_pos;
  logic          best_ok;
  logic [2:0]    best_score;
  nct_pkg::entry_t best;
  logic          req_bad;

  logic            cv [ENTRY_COUNT];
  nct_pkg::entry_t ce [ENTRY_COUNT];

  // Head cell view (cell 0)
  logic            h_valid;
  nct_pkg::entry_t h;
  logic            key_match;
  logic [3:0]      h_score;
  logic            rtr_cand;
  logic            better;
  logic            kill_head;
  logic            shift;
  logic            load_en;
  logic [CW-1:0]   load_pos;

  assign h_valid = cv[0];
  assign h = ce[0];
  assign key_match = h_valid && h.ip_high == req.ip_high && h.ip_low == req.ip_low &&
                     h.group_id == req.group_id;
  assign h_score = nct_pkg::state_rank(h.nud_code);
  assign rtr_cand = h_valid && h.router_flag && h.interface_id == req.interface_id &&
                    h.group_id == req.group_id && !h_score[3] && h_score[2:0] != 3'd0;
  assign better = rtr_cand && (!best_ok || h_score[2:0] > best_score ||
                  (h_score[2:0] == best_score && (h.ip_high < best.ip_high ||
                   (h.ip_high == best.ip_high && h.ip_low < best.ip_low))));

  // Drop the head entry as it wraps round to the tail cell
  always_comb begin
    kill_head = 1'b0;
    if (state == S_WALK && h_valid) begin
      case (op)
        nct_pkg::OP_REMOVE:  kill_head = key_match && !hit;
        nct_pkg::OP_CLR_IFC: kill_head = h.interface_id == req.interface_id;
        nct_pkg::OP_CLR_GRP: kill_head = h.group_id == req.group_id;
        nct_pkg::OP_CLR_EXP: kill_head = h.expiry <= req.expiry;
        default:             kill_head = 1'b0;
      endcase
    end
  end

  assign shift = state == S_WALK;
  // After a full rotation cell i again holds slot i
  assign load_en = state == S_COMMIT && op == nct_pkg::OP_INSERT && !req_bad &&
                   (hit || has_free);
  assign load_pos = hit ? hit_pos : free_pos;

  nct_pkg::entry_t ins;
  always_comb begin
    ins = req;
    ins.expiry = req.expiry + expiry_timeout;
  end

  genvar g;
  generate
    for (g = 0; g < ENTRY_COUNT; g++) begin : g_cell
      localparam int P = (g + 1) % ENTRY_COUNT;
      nct_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .clr_all   (state == S_WALK && op == nct_pkg::OP_CLR_ALL),
        .load      (load_en && load_pos == CW'(g)),
        .load_entry(ins),
        .prev_valid(g == ENTRY_COUNT - 1 ? (cv[0] && !kill_head) : cv[P]),
        .prev_entry(ce[P]),
        .valid     (cv[g]),
        .entry     (ce[g])
      );
    end
  endgenerate

  assign in_stall = state != S_IDLE || out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid && !in_stall) state_next = S_WALK;
      S_WALK:   if (cnt == CW'(ENTRY_COUNT - 1)) state_next = S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_DONE:   if (!out_valid) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      expiry_timeout <= nct_pkg::TIMEOUT_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) expiry_timeout <= cfg_wdata;
    end
  end

  // Latch request and track walk results; expiry field carries now
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) begin
      op <= operation;
      req.ip_high <= ip_high;
      req.ip_low <= ip_low;
      req.group_id <= group_id;
      req.interface_id <= interface_id;
      req.link_addr <= link_addr;
      req.router_flag <= router_flag;
      req.nud_code <= nud_code;
      req.expiry <= now;
      req_bad <= !link_addr_valid || interface_id == 4'd0 ||
                 32'(interface_id) >= 32'(INTERFACE_IDS) || group_id == 4'd0 ||
                 32'(group_id) >= 32'(GROUP_IDS) || nct_pkg::state_rank(nud_code) > 4'd5;
      cnt <= '0;
      hit <= 1'b0;
      has_free <= 1'b0;
      best_ok <= 1'b0;
    end else if (state == S_WALK) begin
      cnt <= cnt + 1'b1;
      if (key_match && !hit) begin
        hit <= 1'b1;
        hit_pos <= cnt;
        if (op == nct_pkg::OP_LOOKUP) best <= h;
      end
      if (!h_valid && !has_free) begin
        has_free <= 1'b1;
        free_pos <= cnt;
      end
      if (op == nct_pkg::OP_ROUTER && better) begin
        best_ok <= 1'b1;
        best_score <= h_score[2:0];
        best <= h;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_COMMIT) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  logic ret;
  always_comb begin
    case (op)
      nct_pkg::OP_LOOKUP: ret = hit;
      nct_pkg::OP_ROUTER: ret = best_ok;
      default:            ret = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_COMMIT) begin
      case (op)
        nct_pkg::OP_LOOKUP:
          status <= hit ? nct_pkg::ST_OK : nct_pkg::ST_NOTFOUND;
        nct_pkg::OP_ROUTER:
          status <= best_ok ? nct_pkg::ST_OK : nct_pkg::ST_NOTFOUND;
        nct_pkg::OP_INSERT:
          status <= req_bad ? nct_pkg::ST_INVALID :
                    (hit || has_free) ? nct_pkg::ST_OK : nct_pkg::ST_FULL;
        nct_pkg::OP_REMOVE:
          status <= hit ? nct_pkg::ST_OK : nct_pkg::ST_NOTFOUND;
        default: status <= nct_pkg::ST_OK;
      endcase
      found <= ret;
      out_ip_high <= ret ? best.ip_high : 64'd0;
      out_ip_low <= ret ? best.ip_low : 64'd0;
      out_link_addr <= ret ? best.link_addr : 48'd0;
      out_interface_id <= ret ? best.interface_id : 4'd0;
      out_router_flag <= ret ? best.router_flag : 1'b0;
      out_nud_code <= ret ? best.nud_code : 8'd0;
      out_expiry <= ret ? best.expiry : 32'd0;
    end
  end

endmodule

@@ rtl/core/nct_checker.sv @@
// Port-level checker for the neighbour cache table, bound to the top level.
// Depends on nct_pkg.
module nct_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       found
);

  a_one_outstanding: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("accept not followed by busy");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> status == nct_pkg::ST_OK) else $error("found with bad status");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status))
    else $error("stalled result changed");

endmodule

bind neighbor_cache_table nct_checker u_nct_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status   (status),
  .found    (found)
);

@@ verif/tb.sv @@
// Self-checking bench for neighbor_cache_table: directed table, a fill to capacity, then random traffic.
// Depends on nct_pkg and the neighbor_cache_table RTL.
`timescale 1ns / 100ps
module tb;

  localparam int SLOTS = 64;
  localparam int IDS = 16;
  localparam int WATCHDOG = 20000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int NOCHK = -1;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [3:0]  group_id;
    logic [3:0]  interface_id;
    logic [47:0] link_addr;
    logic        link_valid;
    logic        router_flag;
    logic [7:0]  nud_code;
    logic [31:0] now;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [47:0] link_addr;
    logic [3:0]  interface_id;
    logic        router_flag;
    logic [7:0]  nud_code;
    logic [31:0] expiry;
  } reply_t;

  typedef struct {
    request_t req;
    logic     has_status;
    logic [1:0] status;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = '0;
  logic [63:0] ip_high = '0, ip_low = '0;
  logic [3:0] group_id = '0, interface_id = '0;
  logic [47:0] link_addr = '0;
  logic link_addr_valid = 1'b0, router_flag = 1'b0;
  logic [7:0] nud_code = '0;
  logic [31:0] now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic found;
  logic [63:0] out_ip_high, out_ip_low;
  logic [47:0] out_link_addr;
  logic [3:0] out_interface_id;
  logic out_router_flag;
  logic [7:0] out_nud_code;
  logic [31:0] out_expiry;

  neighbor_cache_table i_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .operation, .ip_high,
    .ip_low, .group_id, .interface_id, .link_addr, .link_addr_valid, .router_flag,
    .nud_code, .now, .out_valid, .out_stall, .status, .found, .out_ip_high,
    .out_ip_low, .out_link_addr, .out_interface_id, .out_router_flag,
    .out_nud_code, .out_expiry
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the neighbour table
  logic            nb_valid [SLOTS];
  nct_pkg::entry_t nb_entry [SLOTS];
  logic [31:0]     nb_timeout;

  reply_t pending_replies[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet_phase = 1'b0;
  bit  hold_off = 1'b0;
  int  row_status = NOCHK;  // typed-in status, driven alongside the payload
  int  typed_status[$];

  function automatic int rank(input logic [7:0] code);
    case (code)
      nct_pkg::NS_REACHABLE:  return 5;
      nct_pkg::NS_PROBE:      return 4;
      nct_pkg::NS_DELAY:      return 3;
      nct_pkg::NS_STALE:      return 2;
      nct_pkg::NS_INCOMPLETE: return 1;
      nct_pkg::NS_FAILED:     return 0;
      default:                return -1;
    endcase
  endfunction

  function automatic int find_slot(input request_t r);
    for (int i = 0; i < SLOTS; i++)
      if (nb_valid[i] && nb_entry[i].ip_high == r.ip_high &&
          nb_entry[i].ip_low == r.ip_low && nb_entry[i].group_id == r.group_id)
        return i;
    return -1;
  endfunction

  function automatic reply_t neighbour_reply(input request_t r);
    reply_t rep;
    int hit, best, best_rank, s;
    rep = '{default: '0};
    hit = -1;
    case (r.op)
      nct_pkg::OP_LOOKUP: hit = find_slot(r);
      nct_pkg::OP_ROUTER: begin
        best = -1;
        best_rank = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!nb_valid[i] || !nb_entry[i].router_flag ||
              nb_entry[i].interface_id != r.interface_id ||
              nb_entry[i].group_id != r.group_id)
            continue;
          s = rank(nb_entry[i].nud_code);
          if (s > best_rank || (s == best_rank && best >= 0 &&
              {nb_entry[i].ip_high, nb_entry[i].ip_low} <
              {nb_entry[best].ip_high, nb_entry[best].ip_low})) begin
            best_rank = s;
            best = i;
          end
        end
        hit = best;
      end
      nct_pkg::OP_INSERT: begin
        if (!r.link_valid || r.interface_id == 0 || r.interface_id >= IDS ||
            r.group_id == 0 || r.group_id >= IDS || rank(r.nud_code) < 0) begin
          rep.status = nct_pkg::ST_INVALID;
        end else begin
          s = find_slot(r);
          if (s < 0)
            for (int i = SLOTS - 1; i >= 0; i--)
              if (!nb_valid[i]) s = i;
          if (s < 0) begin
            rep.status = nct_pkg::ST_FULL;
          end else begin
            nb_valid[s] = 1'b1;
            nb_entry[s] = '{r.ip_high, r.ip_low, r.group_id, r.interface_id,
                            r.link_addr, r.router_flag, r.nud_code,
                            r.now + nb_timeout};
          end
        end
        return rep;
      end
      nct_pkg::OP_REMOVE: begin
        s = find_slot(r);
        if (s < 0) rep.status = nct_pkg::ST_NOTFOUND;
        else nb_valid[s] = 1'b0;
        return rep;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++)
          if (nb_valid[i] && (r.op == nct_pkg::OP_CLR_ALL ||
              (r.op == nct_pkg::OP_CLR_IFC &&
               nb_entry[i].interface_id == r.interface_id) ||
              (r.op == nct_pkg::OP_CLR_GRP && nb_entry[i].group_id == r.group_id) ||
              (r.op == nct_pkg::OP_CLR_EXP && nb_entry[i].expiry <= r.now)))
            nb_valid[i] = 1'b0;
        return rep;
      end
    endcase
    if (hit < 0) begin
      rep.status = nct_pkg::ST_NOTFOUND;
    end else begin
      rep.found = 1'b1;
      rep.ip_high = nb_entry[hit].ip_high;
      rep.ip_low = nb_entry[hit].ip_low;
      rep.link_addr = nb_entry[hit].link_addr;
      rep.interface_id = nb_entry[hit].interface_id;
      rep.router_flag = nb_entry[hit].router_flag;
      rep.nud_code = nb_entry[hit].nud_code;
      rep.expiry = nb_entry[hit].expiry;
    end
    return rep;
  endfunction

  // Predict at acceptance so table state follows transaction order
  always @(posedge clk) begin
    request_t r;
    if (!rst && in_valid && !in_stall) begin
      r = '{operation, ip_high, ip_low, group_id, interface_id, link_addr,
            link_addr_valid, router_flag, nud_code, now};
      pending_replies.push_back(neighbour_reply(r));
      typed_status.push_back(row_status);
    end
  end

  task automatic flag(input string what, input logic [63:0] exp_v, act_v);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t e;
    int ts;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        errors++;
      end else begin
        e = pending_replies.pop_front();
        ts = typed_status.pop_front();
        if (ts >= 0 && status !== ts[1:0]) flag("typed status", 64'(ts), 64'(status));
        if (status !== e.status) flag("status", 64'(e.status), 64'(status));
        if (found !== e.found) flag("found", 64'(e.found), 64'(found));
        if (out_ip_high !== e.ip_high) flag("out_ip_high", e.ip_high, out_ip_high);
        if (out_ip_low !== e.ip_low) flag("out_ip_low", e.ip_low, out_ip_low);
        if (out_link_addr !== e.link_addr)
          flag("out_link_addr", 64'(e.link_addr), 64'(out_link_addr));
        if (out_interface_id !== e.interface_id)
          flag("out_interface_id", 64'(e.interface_id), 64'(out_interface_id));
        if (out_router_flag !== e.router_flag)
          flag("out_router_flag", 64'(e.router_flag), 64'(out_router_flag));
        if (out_nud_code !== e.nud_code)
          flag("out_nud_code", 64'(e.nud_code), 64'(out_nud_code));
        if (out_expiry !== e.expiry) flag("out_expiry", 64'(e.expiry), 64'(out_expiry));
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, or a long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input request_t r, input int ts);
    int n;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    row_status <= ts;
    operation <= r.op;
    ip_high <= r.ip_high;
    ip_low <= r.ip_low;
    group_id <= r.group_id;
    interface_id <= r.interface_id;
    link_addr <= r.link_addr;
    link_addr_valid <= r.link_valid;
    router_flag <= r.router_flag;
    nud_code <= r.nud_code;
    now <= r.now;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    nb_timeout = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] pick_nud();
    logic [7:0] codes[6] = '{nct_pkg::NS_INCOMPLETE, nct_pkg::NS_REACHABLE,
                             nct_pkg::NS_STALE, nct_pkg::NS_DELAY,
                             nct_pkg::NS_PROBE, nct_pkg::NS_FAILED};
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return codes[$urandom_range(0, 5)];
  endfunction

  // Mostly a small key pool so inserts, lookups and removes meet each other
  function automatic request_t random_request(input int pool, input logic [31:0] t);
    request_t r;
    int k;
    k = $urandom_range(0, pool - 1);
    r.op = $urandom_range(0, 15) < 12 ?
           ($urandom_range(0, 3) == 0 ? nct_pkg::OP_INSERT : 3'($urandom_range(0, 3))) :
           3'($urandom_range(4, 7));
    if ($urandom_range(0, 1)) r.op = nct_pkg::OP_INSERT;
    if (r.op >= nct_pkg::OP_CLR_IFC && $urandom_range(0, 3) != 0) r.op = nct_pkg::OP_LOOKUP;
    if ($urandom_range(0, 9) == 0) begin
      r.ip_high = rand64();
      r.ip_low = rand64();
    end else begin
      r.ip_high = {k[3] ? 16'hFFFF : 16'h0, 48'(k[2:1])};
      r.ip_low = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 32'(k)};
    end
    r.group_id = $urandom_range(0, 20) == 0 ? 4'd0 : 4'($urandom_range(1, 3));
    r.interface_id = $urandom_range(0, 20) == 0 ? 4'd0 : 4'($urandom_range(1, 3));
    if ($urandom_range(0, 15) == 0) begin
      r.group_id = 4'($urandom_range(0, 15));
      r.interface_id = 4'($urandom_range(0, 15));
    end
    r.link_addr = 48'({$urandom(), $urandom()});
    r.link_valid = $urandom_range(0, 19) != 0;
    r.router_flag = $urandom_range(0, 3) != 0;
    r.nud_code = pick_nud();
    r.now = $urandom_range(0, 7) == 0 ? $urandom() : t;
    return r;
  endfunction

  localparam logic [63:0] ONES = '1;

  row_t directed[$] = '{
    '{'{nct_pkg::OP_LOOKUP, 64'h0, 64'h0, 4'd1, 4'd1, 48'h0, 1'b1, 1'b0,
        nct_pkg::NS_REACHABLE, 32'd0}, 1'b1, nct_pkg::ST_NOTFOUND},
    '{'{nct_pkg::OP_ROUTER, 64'h0, 64'h0, 4'd1, 4'd1, 48'h0, 1'b1, 1'b0,
        nct_pkg::NS_REACHABLE, 32'd0}, 1'b1, nct_pkg::ST_NOTFOUND},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h0, 4'd1, 4'd1, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1,
        nct_pkg::NS_REACHABLE, 32'd0}, 1'b1, nct_pkg::ST_INVALID},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h0, 4'd0, 4'd1, 48'h0, 1'b1, 1'b1,
        nct_pkg::NS_REACHABLE, 32'd0}, 1'b1, nct_pkg::ST_INVALID},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h0, 4'd1, 4'd0, 48'h0, 1'b1, 1'b1,
        nct_pkg::NS_REACHABLE, 32'd0}, 1'b1, nct_pkg::ST_INVALID},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h0, 4'd1, 4'd1, 48'h0, 1'b1, 1'b1, 8'hFF, 32'd0},
      1'b1, nct_pkg::ST_INVALID},
    '{'{nct_pkg::OP_INSERT, ONES, ONES, 4'd15, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1,
        nct_pkg::NS_REACHABLE, 32'hFFFF_FFFF}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h1, 4'd15, 4'd15, 48'h1, 1'b1, 1'b1,
        nct_pkg::NS_REACHABLE, 32'd5}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h2, 4'd15, 4'd15, 48'h2, 1'b1, 1'b1,
        nct_pkg::NS_FAILED, 32'd5}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h3, 4'd15, 4'd15, 48'h3, 1'b1, 1'b1,
        nct_pkg::NS_PROBE, 32'd5}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h4, 4'd15, 4'd15, 48'h4, 1'b1, 1'b1,
        nct_pkg::NS_DELAY, 32'd5}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h5, 4'd15, 4'd15, 48'h5, 1'b1, 1'b1,
        nct_pkg::NS_STALE, 32'd5}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_INSERT, 64'h0, 64'h6, 4'd15, 4'd15, 48'h6, 1'b1, 1'b0,
        nct_pkg::NS_INCOMPLETE, 32'd5}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_ROUTER, 64'h0, 64'h0, 4'd15, 4'd15, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b0, 2'd0},
    '{'{nct_pkg::OP_LOOKUP, ONES, ONES, 4'd15, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b0, 2'd0},
    '{'{nct_pkg::OP_REMOVE, 64'h0, 64'h1, 4'd15, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_REMOVE, 64'h0, 64'h1, 4'd15, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b1, nct_pkg::ST_NOTFOUND},
    '{'{nct_pkg::OP_ROUTER, 64'h0, 64'h0, 4'd15, 4'd15, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b0, 2'd0},
    '{'{nct_pkg::OP_CLR_EXP, 64'h0, 64'h0, 4'd0, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0,
        32'd30005}, 1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_LOOKUP, ONES, ONES, 4'd15, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b0, 2'd0},
    '{'{nct_pkg::OP_CLR_IFC, 64'h0, 64'h0, 4'd0, 4'd15, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_CLR_GRP, 64'h0, 64'h0, 4'd15, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b1, nct_pkg::ST_OK},
    '{'{nct_pkg::OP_CLR_ALL, 64'h0, 64'h0, 4'd0, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0, 32'd0},
      1'b1, nct_pkg::ST_OK}
  };

  initial begin
    request_t r;
    logic [31:0] clock_ticks;
    logic [31:0] timeouts[4] = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd5000};
    int sent;
    for (int i = 0; i < SLOTS; i++) nb_valid[i] = 1'b0;
    nb_timeout = nct_pkg::TIMEOUT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send(directed[i].req, directed[i].has_status ? int'(directed[i].status) : NOCHK);
    drain();

    // Fill to capacity and overflow once
    for (int i = 0; i <= SLOTS; i++) begin
      r = '{nct_pkg::OP_INSERT, 64'h7, 64'(i), 4'd2, 4'd2, 48'(i), 1'b1, 1'b1,
            nct_pkg::NS_STALE, 32'(i)};
      send(r, i == SLOTS ? int'(nct_pkg::ST_FULL) : NOCHK);
    end
    // Sender keeps offering while the receiver holds off
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) begin
      r.op = nct_pkg::OP_LOOKUP;
      r.ip_low = 64'(i);
      send(r, NOCHK);
    end
    drain();

    sent = 0;
    clock_ticks = 32'd1000;
    for (int phase = 0; phase < 4; phase++) begin
      set_timeout(timeouts[phase]);
      r = '{nct_pkg::OP_CLR_ALL, 64'h0, 64'h0, 4'd0, 4'd0, 48'h0, 1'b0, 1'b0, 8'h0,
            32'd0};
      send(r, NOCHK);
      quiet_phase = phase == 3;
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        clock_ticks += $urandom_range(0, 60);
        send(random_request(phase == 1 ? 80 : 16, clock_ticks), NOCHK);
        sent++;
      end
      drain();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/nct_pkg.sv
rtl/core/nct_cell.sv
rtl/core/neighbor_cache_table.sv
rtl/core/nct_checker.sv
verif/tb.sv
